>>> hdl/tdct_pkg.sv
// Shared types and constants for the triple down counter timer block.
package tdct_pkg;

   localparam int unsigned NumTimers = 3;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned TimerIdxWidth = 2;

   localparam logic [CountWidth-1:0] ReloadResetValue = 16'hffff;
   localparam logic [CountWidth-1:0] LowByteMask = 16'h00ff;
   localparam logic [CountWidth-1:0] HighByteMask = 16'hff00;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef struct packed {
      action_type action;
      logic [2:0] reg_index;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [2:0] irq_flags;
      logic [7:0] read_data;
   } rsp_type;

endpackage

>>> hdl/tdct_timers.sv
// Counter state of the three timers and the single-pass update for one beat.
module tdct_timers (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  tdct_pkg::req_type   req,
   output tdct_pkg::rsp_type   rsp
);

   logic [tdct_pkg::CountWidth-1:0] cnt_ff [tdct_pkg::NumTimers];
   logic [tdct_pkg::CountWidth-1:0] cnt_in [tdct_pkg::NumTimers];
   logic [tdct_pkg::CountWidth-1:0] reload_ff;
   logic [tdct_pkg::CountWidth-1:0] reload_in;
   logic [tdct_pkg::NumTimers-1:0]  stopped_ff;
   logic [tdct_pkg::NumTimers-1:0]  stopped_in;

   logic [tdct_pkg::TimerIdxWidth-1:0] timer;
   logic                               high;
   logic [tdct_pkg::CountWidth-1:0]    byte_word;
   logic [tdct_pkg::CountWidth-1:0]    byte_mask;
   logic [tdct_pkg::CountWidth-1:0]    base;
   logic [tdct_pkg::CountWidth-1:0]    dec;

   assign timer = req.reg_index[2:1];
   assign high  = req.reg_index[0];

   // The written byte placed in its lane, and the mask of the lane that is kept.
   assign byte_word = high ? {req.write_data, 8'h00} : {8'h00, req.write_data};
   assign byte_mask = high ? tdct_pkg::LowByteMask : tdct_pkg::HighByteMask;

   always_comb begin
      cnt_in     = cnt_ff;
      reload_in  = reload_ff;
      stopped_in = stopped_ff;
      rsp        = '0;
      base       = '0;
      dec        = '0;
      case (req.action)
         tdct_pkg::ACT_WRITE: begin
            for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
               if (timer == tdct_pkg::TimerIdxWidth'(t)) begin
                  stopped_in[t] = !high;
                  cnt_in[t]     = (cnt_ff[t] & byte_mask) | byte_word;
               end
            end
            if (timer == '0) begin
               reload_in = (reload_ff & byte_mask) | byte_word;
            end
         end
         tdct_pkg::ACT_READ: begin
            for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
               if (timer == tdct_pkg::TimerIdxWidth'(t)) begin
                  rsp.read_data = high ? cnt_ff[t][15:8] : cnt_ff[t][7:0];
               end
            end
         end
         tdct_pkg::ACT_TICK: begin
            for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
               // Timer 0 reloads before counting when it already sits at zero.
               if (t == 0 && cnt_ff[t] == '0) begin
                  base = reload_ff;
               end else begin
                  base = cnt_ff[t];
               end
               dec = base - 16'd1;
               if (!stopped_ff[t]) begin
                  cnt_in[t]        = dec;
                  rsp.irq_flags[t] = (dec == '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
            cnt_ff[t] <= '0;
         end
         reload_ff  <= tdct_pkg::ReloadResetValue;
         stopped_ff <= '0;
      end else if (fire) begin
         cnt_ff     <= cnt_in;
         reload_ff  <= reload_in;
         stopped_ff <= stopped_in;
      end
   end

   a_irq_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req.action != tdct_pkg::ACT_TICK) |-> (rsp.irq_flags == '0))
      else $error("interrupt flag raised on a beat that is not a tick");

   a_low_write_stops: assert property (@(posedge clock) disable iff (reset)
      (fire && req.action == tdct_pkg::ACT_WRITE && !high && timer < tdct_pkg::NumTimers)
      |=> stopped_ff[$past(timer)])
      else $error("low byte write did not stop its timer");

   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && req.action == tdct_pkg::ACT_TICK && stopped_ff[2])
      |=> $stable(cnt_ff[2]))
      else $error("stopped timer 2 changed on a tick");

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (fire && req.action == tdct_pkg::ACT_READ) |=> $stable(reload_ff))
      else $error("reload value changed on a read");

endmodule

>>> hdl/triple_down_counter_timers.sv
// Top level of the three down counter timers with request and response registers.
//
//  Channel | Direction | Payload
//  req     | in        | tuser: action[1:0]; tdata: reg_index[2:0], write_data[10:3]
//  rsp     | out       | tdata: read_data[7:0], irq_flags[10:8]
//
// A beat passes through the request register and then the response register before its
// response can be taken; a new beat is taken every cycle while the response side does not stall.
// Counter state updates at the edge where a beat moves into the response register, so
// back-to-back beats always see each other's effects.
// Synchronous reset clears counters, stop bits and valid flags and sets reload to all ones.
// A stalled response side holds the request register once it fills, and req_tready drops.
module triple_down_counter_timers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // action[1:0]
   input  logic [15:0] req_tdata,   // reg_index[2:0], write_data[10:3], zero[15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data[7:0], irq_flags[10:8], zero[15:11]
);

   tdct_pkg::req_type req_ff;
   tdct_pkg::req_type req_in;
   logic              req_valid_ff;
   tdct_pkg::rsp_type rsp_ff;
   tdct_pkg::rsp_type rsp_in;
   logic              rsp_valid_ff;

   logic req_fire;
   logic advance;

   // The request register moves on whenever the response register is empty or drains.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign req_in.action     = tdct_pkg::action_type'(req_tuser);
   assign req_in.reg_index  = req_tdata[2:0];
   assign req_in.write_data = req_tdata[10:3];

   tdct_timers u_timers (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.irq_flags, rsp_ff.read_data};

   a_not_ready_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (req_valid_ff && rsp_valid_ff))
      else $error("request side stalled with room in the pipeline");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("beat left the request register but no response appeared");

   a_stall_holds_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_ff)))
      else $error("waiting request was lost or overwritten");

endmodule

>>> bench/tb_triple_down_counter_timers.sv
// Self-checking stream testbench for the triple down counter timers block.
module tb_triple_down_counter_timers;
   timeunit 1ns;
   timeprecision 1ps;

   localparam real ClockPeriod = 12.0;
   localparam int unsigned ResetCycles = 8;
   // Action code the block must treat as a no-op.
   localparam logic [1:0] ActUnused = 2'd3;
   // Register indexes, including the two that lie past the last timer.
   localparam logic [2:0] RegT0Low = 3'd0;
   localparam logic [2:0] RegT0High = 3'd1;
   localparam logic [2:0] RegT1Low = 3'd2;
   localparam logic [2:0] RegT1High = 3'd3;
   localparam logic [2:0] RegT2Low = 3'd4;
   localparam logic [2:0] RegT2High = 3'd5;
   localparam logic [2:0] RegSpareLow = 3'd6;
   localparam logic [2:0] RegSpareHigh = 3'd7;
   // Two register stages sit between request and response.
   localparam int unsigned PipeLatency = 2;
   localparam int unsigned IdlePercent = 31;
   localparam int unsigned StallLimit = 500;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // action[1:0]
   logic [15:0] req_tdata;   // reg_index[2:0], write_data[10:3], zero[15:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // read_data[7:0], irq_flags[10:8], zero[15:11]

   // Shadow copy of the timer state, advanced once per accepted request beat.
   logic [tdct_pkg::CountWidth-1:0] shadow_count [tdct_pkg::NumTimers];
   logic [tdct_pkg::CountWidth-1:0] shadow_reload;
   bit                              shadow_halted [tdct_pkg::NumTimers];

   tdct_pkg::rsp_type timer_rsp_q [$];
   int unsigned beats_sent = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   triple_down_counter_timers DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(ClockPeriod / 2.0) clock = ~clock;

   // Applies one request to the shadow state and returns the response it must produce.
   function automatic tdct_pkg::rsp_type compute_timer_rsp(input logic [1:0] action,
                                                           input logic [2:0] reg_index,
                                                           input logic [7:0] data);
      tdct_pkg::rsp_type                 rsp;
      int unsigned                       timer;
      bit                                high;
      logic [tdct_pkg::CountWidth-1:0]   byte_word;
      logic [tdct_pkg::CountWidth-1:0]   keep_mask;
      rsp = '0;
      timer = 32'(reg_index[2:1]);
      high = reg_index[0];
      byte_word = high ? {data, 8'h00} : {8'h00, data};
      keep_mask = high ? tdct_pkg::LowByteMask : tdct_pkg::HighByteMask;
      case (action)
         tdct_pkg::ACT_WRITE: begin
            if (timer < tdct_pkg::NumTimers) begin
               // A low byte halts the timer, a high byte lets it run again.
               shadow_halted[timer] = !high;
               shadow_count[timer] = (shadow_count[timer] & keep_mask) | byte_word;
               if (timer == 0)
                  shadow_reload = (shadow_reload & keep_mask) | byte_word;
            end
         end
         tdct_pkg::ACT_READ: begin
            if (timer < tdct_pkg::NumTimers)
               rsp.read_data = high ? shadow_count[timer][15:8] : shadow_count[timer][7:0];
         end
         tdct_pkg::ACT_TICK: begin
            for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
               if (!shadow_halted[t]) begin
                  // Timer 0 reloads before counting when it already sits at zero.
                  if (t == 0 && shadow_count[0] == '0)
                     shadow_count[0] = shadow_reload;
                  shadow_count[t] = shadow_count[t] - 16'd1;
                  if (shadow_count[t] == '0)
                     rsp.irq_flags[t] = 1'b1;
               end
            end
         end
         default: begin
            // The spare action code leaves everything alone.
         end
      endcase
      return rsp;
   endfunction

   // Presents one request beat, with a random gap in front of it while idling is on, and waits
   // for the handshake. The expected response is queued at the edge that accepts the beat.
   task automatic send_beat(input logic [1:0] action, input logic [2:0] reg_index,
                            input logic [7:0] data);
      if (req_idle_on && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IdlePercent);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {5'b0, data, reg_index};
      do @(posedge clock); while (!req_tready);
      timer_rsp_q.push_back(compute_timer_rsp(action, reg_index, data));
      beats_sent++;
   endtask

   // Stops sending and waits until every queued response has been seen.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (timer_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // Every register reads back its reset value; the two spare indexes read zero.
   task automatic test_reset_values();
      for (int r = 0; r < 8; r++)
         send_beat(tdct_pkg::ACT_READ, r[2:0], 8'h00);
   endtask

   // Timer 0 with a zero reload goes straight to all ones without a flag, while
   // timers 1 and 2 flag on reaching zero and then wrap to all ones.
   task automatic test_zero_reload_and_wrap();
      send_beat(tdct_pkg::ACT_WRITE, RegT0Low, 8'h00);
      send_beat(tdct_pkg::ACT_WRITE, RegT0High, 8'h00);
      send_beat(tdct_pkg::ACT_WRITE, RegT1Low, 8'h01);
      send_beat(tdct_pkg::ACT_WRITE, RegT1High, 8'h00);
      send_beat(tdct_pkg::ACT_WRITE, RegT2Low, 8'h01);
      send_beat(tdct_pkg::ACT_WRITE, RegT2High, 8'h00);
      send_beat(tdct_pkg::ACT_TICK, RegT0Low, 8'h00);
      send_beat(tdct_pkg::ACT_TICK, RegT0Low, 8'h00);
      send_beat(tdct_pkg::ACT_READ, RegT0Low, 8'h00);
      send_beat(tdct_pkg::ACT_READ, RegT0High, 8'h00);
      send_beat(tdct_pkg::ACT_READ, RegT1High, 8'h00);
   endtask

   // Writes past the last timer and the spare action code must leave the counters alone, and
   // a tick must leave a halted timer 0 alone.
   task automatic test_ignored_items();
      send_beat(tdct_pkg::ACT_WRITE, RegSpareLow, 8'hff);
      send_beat(tdct_pkg::ACT_WRITE, RegSpareHigh, 8'haa);
      send_beat(ActUnused, RegT2High, 8'h55);
      send_beat(tdct_pkg::ACT_WRITE, RegT0Low, 8'hff);
      send_beat(tdct_pkg::ACT_TICK, RegSpareHigh, 8'hff);
      send_beat(tdct_pkg::ACT_READ, RegT0Low, 8'h00);
   endtask

   // Mostly well-formed timer programs with small start values so that flags and
   // reloads happen often, mixed with fully random beats.
   task automatic test_random_traffic(input int unsigned beat_count);
      int unsigned stop_at;
      int unsigned timer;
      int unsigned run_len;
      logic [7:0]  low_byte;
      logic [7:0]  high_byte;
      stop_at = beats_sent + beat_count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            send_beat(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom_range(255)));
         end else begin
            timer = $urandom_range(tdct_pkg::NumTimers - 1);
            low_byte = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(6));
            case ($urandom_range(7))
               0:       high_byte = 8'hff;
               1:       high_byte = 8'($urandom_range(255));
               default: high_byte = 8'h00;
            endcase
            send_beat(tdct_pkg::ACT_WRITE, {timer[1:0], 1'b0}, low_byte);
            // Now and then the timer is left halted after its low byte.
            if ($urandom_range(4) != 0)
               send_beat(tdct_pkg::ACT_WRITE, {timer[1:0], 1'b1}, high_byte);
            run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(4) == 0)
                  send_beat(tdct_pkg::ACT_READ, 3'($urandom_range(5)),
                            8'($urandom_range(255)));
               else
                  send_beat(tdct_pkg::ACT_TICK, 3'($urandom_range(7)),
                            8'($urandom_range(255)));
            end
         end
      end
   endtask

   // The sender holds off until the block has nothing left in flight, then resumes.
   task automatic test_drain_pause();
      wait_for_drain();
      send_beat(tdct_pkg::ACT_READ, RegT1Low, 8'h00);
      send_beat(tdct_pkg::ACT_TICK, RegT0Low, 8'h00);
   endtask

   // The receiver stalls at random while idling is on and is always ready otherwise.
   always @(posedge clock)
      rsp_tready <= rsp_idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;

   // Each response beat is checked against the oldest queued expectation.
   always @(posedge clock) begin
      tdct_pkg::rsp_type got;
      tdct_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tdct_pkg::rsp_type'(rsp_tdata[10:0]);
         if (timer_rsp_q.size() == 0) begin
            $error("unexpected response beat: read_data %0h, irq_flags %0h",
                   got.read_data, got.irq_flags);
            error_count++;
         end else begin
            want = timer_rsp_q.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
               error_count++;
            end
            if (got.irq_flags !== want.irq_flags) begin
               $error("irq_flags: expected %0h, got %0h", want.irq_flags, got.irq_flags);
               error_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      for (int t = 0; t < tdct_pkg::NumTimers; t++) begin
         shadow_count[t] = '0;
         shadow_halted[t] = 1'b0;
      end
      shadow_reload = tdct_pkg::ReloadResetValue;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_zero_reload_and_wrap();
      test_ignored_items();
      test_random_traffic(500);
      test_drain_pause();
      // A long stretch with both sides running flat out.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(250);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_traffic(350);

      wait_for_drain();
      repeat (PipeLatency + 8) @(posedge clock);
      if (timer_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", timer_rsp_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
